>>> sv/zgks_pkg.sv
// Package for the zone grid key sort block: sizes, payload structs, state enums.
// Used by every module of the block but zgks_ram; depends on nothing.
package zgks_pkg;

	localparam int MAX_ZONES = 16;
	localparam int ADDR_W = $clog2(MAX_ZONES);
	localparam int CNT_W = $clog2(MAX_ZONES + 1);
	localparam int EDGE_W = 12;
	localparam int BANK_W = 13;
	localparam int NUM_W = 13;
	localparam int DIV_W = 8;
	localparam int QUO_W = 13;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [EDGE_W-1:0] GRID_MAX = 12'hFFF;

	localparam logic CFG_BANK_WIDTH = 1'b0;
	localparam logic CFG_BANK_HEIGHT = 1'b1;

	typedef struct packed {
		logic [11:0] rect_left;
		logic [11:0] rect_top;
		logic [11:0] rect_right;
		logic [11:0] rect_bottom;
		logic        last_in;
	} item_t;

	typedef struct packed {
		logic [3:0]  orig_index;
		logic [11:0] out_left;
		logic [11:0] out_top;
		logic [11:0] out_right;
		logic [11:0] out_bottom;
		logic [11:0] grid_col;
		logic [11:0] grid_row;
		logic        dropped;
		logic        last_out;
	} result_t;

	// One stored rectangle; row and col in this order form the sort key.
	typedef struct packed {
		logic [11:0] left;
		logic [11:0] top;
		logic [11:0] right;
		logic [11:0] bottom;
		logic [11:0] row;
		logic [11:0] col;
	} entry_t;

	typedef struct packed {
		entry_t ent;
		logic   last;
	} qword_t;

	typedef enum logic [1:0] {FR_IDLE, FR_DIV, FR_PUSH} front_state_t;
	typedef enum logic [1:0] {BK_LOAD, BK_SCAN, BK_EMIT} back_state_t;

endpackage

>>> sv/zgks_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module zgks_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> sv/zgks_front.sv
// Front end: accepts rectangles and computes their rounded grid row and column.
// Depends on zgks_pkg; feeds zgks_queue.
module zgks_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  zgks_pkg::item_t             item,
	input  logic [zgks_pkg::BANK_W-1:0] bank_width,
	input  logic [zgks_pkg::BANK_W-1:0] bank_height,
	output logic                        push,
	output zgks_pkg::qword_t            push_data,
	input  logic                        q_full
);
	import zgks_pkg::*;

	front_state_t state_q, state_d;
	logic [$clog2(QUO_W+1)-1:0] step_q;
	logic [NUM_W-1:0] cnum_q, rnum_q;
	logic [DIV_W-1:0] cdiv_q, rdiv_q, crem_q, rrem_q;
	logic [QUO_W-1:0] cquo_q, rquo_q;
	item_t item_q;
	logic accept;
	logic [EDGE_W:0] csum, rsum;
	logic [DIV_W:0] ctrial, rtrial;
	logic cbit, rbit;

	function automatic logic [DIV_W-1:0] divisor(input logic [BANK_W-1:0] bank);
		logic [DIV_W-1:0] d;
		d = bank[BANK_W-1:5];
		return (d == '0) ? DIV_W'(1) : d;
	endfunction

	assign accept = start && !busy;
	assign csum = {1'b0, item.rect_left} + {1'b0, item.rect_right};
	assign rsum = {1'b0, item.rect_top} + {1'b0, item.rect_bottom};

	assign ctrial = {crem_q, cnum_q[NUM_W-1]};
	assign rtrial = {rrem_q, rnum_q[NUM_W-1]};
	assign cbit = ctrial >= {1'b0, cdiv_q};
	assign rbit = rtrial >= {1'b0, rdiv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy = 1'b1;
		push = 1'b0;
		unique case (state_q)
			FR_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = FR_DIV;
				end
			end
			FR_DIV: begin
				if (step_q == ($clog2(QUO_W+1))'(QUO_W - 1)) begin
					state_d = FR_PUSH;
				end
			end
			FR_PUSH: begin
				if (!q_full) begin
					push = 1'b1;
					state_d = FR_IDLE;
				end
			end
			default: state_d = FR_IDLE;
		endcase
	end

	// Restoring division, one quotient bit per cycle for both coordinates.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
			cnum_q <= NUM_W'(csum[EDGE_W:1]) + NUM_W'(bank_width[BANK_W-1:6]);
			rnum_q <= NUM_W'(rsum[EDGE_W:1]) + NUM_W'(bank_height[BANK_W-1:6]);
			cdiv_q <= divisor(bank_width);
			rdiv_q <= divisor(bank_height);
			crem_q <= '0;
			rrem_q <= '0;
			step_q <= '0;
		end else if (state_q == FR_DIV) begin
			crem_q <= cbit ? DIV_W'(ctrial - {1'b0, cdiv_q}) : DIV_W'(ctrial);
			rrem_q <= rbit ? DIV_W'(rtrial - {1'b0, rdiv_q}) : DIV_W'(rtrial);
			cquo_q <= {cquo_q[QUO_W-2:0], cbit};
			rquo_q <= {rquo_q[QUO_W-2:0], rbit};
			cnum_q <= {cnum_q[NUM_W-2:0], 1'b0};
			rnum_q <= {rnum_q[NUM_W-2:0], 1'b0};
			step_q <= step_q + 1'b1;
		end
	end

	always_comb begin
		push_data.ent.left = item_q.rect_left;
		push_data.ent.top = item_q.rect_top;
		push_data.ent.right = item_q.rect_right;
		push_data.ent.bottom = item_q.rect_bottom;
		push_data.ent.col = (cquo_q > QUO_W'(GRID_MAX)) ? GRID_MAX : cquo_q[EDGE_W-1:0];
		push_data.ent.row = (rquo_q > QUO_W'(GRID_MAX)) ? GRID_MAX : rquo_q[EDGE_W-1:0];
		push_data.last = item_q.last_in;
	end
endmodule

>>> sv/zgks_queue.sv
// Two entry queue between the front end and the sorting back end.
// Depends on zgks_pkg.
module zgks_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  zgks_pkg::qword_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output zgks_pkg::qword_t pop_data
);
	import zgks_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	qword_t slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [PTR_W:0] count_q;

	assign full = count_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign pop_data = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			count_q <= count_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_data;
		end
	end
endmodule

>>> sv/zgks_back.sv
// Back end: stores rectangles and emits them in ascending key order, one scan per result.
// Depends on zgks_pkg and zgks_ram.
module zgks_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             not_empty,
	input  zgks_pkg::qword_t pop_data,
	output logic             pop,
	output logic             result_valid,
	output zgks_pkg::result_t result
);
	import zgks_pkg::*;

	localparam int SORT_W = 2 * EDGE_W + ADDR_W;

	back_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, scan_q;
	logic [ADDR_W-1:0] pass_q, rd_addr_s1, best_addr_q;
	logic rd_v_s1, ovf_q, have_prev_q, best_v_q;
	logic [SORT_W-1:0] prev_q, best_q, cand;
	entry_t best_ent_q, rdata;
	logic we, issue, take, ovf_now;

	assign pop = (state_q == BK_LOAD) && not_empty;
	assign we = pop && (cnt_q < CNT_W'(MAX_ZONES));
	assign ovf_now = ovf_q || (pop && !we);
	assign issue = (state_q == BK_SCAN) && (scan_q < cnt_q);

	zgks_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_ZONES)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (pop_data.ent),
		.raddr (scan_q[ADDR_W-1:0]),
		.rdata (rdata)
	);

	// Equal keys stay in arrival order because the address is the lowest key part.
	assign cand = {rdata.row, rdata.col, rd_addr_s1};
	assign take = rd_v_s1 && (!have_prev_q || cand > prev_q) && (!best_v_q || cand < best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_LOAD: begin
				if (pop && pop_data.last) begin
					state_d = BK_SCAN;
				end
			end
			BK_SCAN: begin
				if (!issue && !rd_v_s1) begin
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: begin
				state_d = (CNT_W'(pass_q) + 1'b1 == cnt_q) ? BK_LOAD : BK_SCAN;
			end
			default: state_d = BK_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
			scan_q <= '0;
			pass_q <= '0;
			rd_v_s1 <= 1'b0;
			have_prev_q <= 1'b0;
			best_v_q <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			rd_v_s1 <= issue;
			if (issue) begin
				scan_q <= scan_q + 1'b1;
			end
			if (take) begin
				best_v_q <= 1'b1;
			end
			unique case (state_q)
				BK_LOAD: begin
					if (we) begin
						cnt_q <= cnt_q + 1'b1;
					end
					ovf_q <= ovf_now;
					scan_q <= '0;
					pass_q <= '0;
					have_prev_q <= 1'b0;
					best_v_q <= 1'b0;
				end
				BK_SCAN: ;
				BK_EMIT: begin
					result_valid <= 1'b1;
					have_prev_q <= 1'b1;
					best_v_q <= 1'b0;
					scan_q <= '0;
					pass_q <= pass_q + 1'b1;
					if (state_d == BK_LOAD) begin
						cnt_q <= '0;
						ovf_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= scan_q[ADDR_W-1:0];
		if (take) begin
			best_q <= cand;
			best_ent_q <= rdata;
			best_addr_q <= rd_addr_s1;
		end
		if (state_q == BK_EMIT) begin
			prev_q <= best_q;
			result.orig_index <= 4'(best_addr_q);
			result.out_left <= best_ent_q.left;
			result.out_top <= best_ent_q.top;
			result.out_right <= best_ent_q.right;
			result.out_bottom <= best_ent_q.bottom;
			result.grid_col <= best_ent_q.col;
			result.grid_row <= best_ent_q.row;
			result.dropped <= ovf_q;
			result.last_out <= state_d == BK_LOAD;
		end
	end

	a_no_pop_while_sorting: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != BK_LOAD) |-> !pop) else $error("queue popped during sort");
	a_emit_has_winner: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_EMIT) |-> best_v_q) else $error("emit without a selected entry");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_ZONES)) else $error("entry count beyond capacity");
	a_result_follows_emit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q) == BK_EMIT) else $error("stray result strobe");
endmodule

>>> sv/zone_grid_key_sort.sv
// Top level of the zone grid key sort block: config registers, front end, queue, back end.
// Depends on zgks_pkg, zgks_front, zgks_queue, zgks_back and zgks_ram.
//
// channel   signals                          transfer when
// item      start, busy, item                start high and busy low
// result    result_valid, result             result_valid high (one cycle)
// config    cfg_we, cfg_index, cfg_data      cfg_we high
//
// A rectangle occupies the front end from its load through the bit-serial grid divisions
// to its hand-off to the queue; the front end takes no new rectangle before then.
// After the last rectangle of a set, each result takes one full scan of the entry RAM
// through its single read port, then the registered read data and the emit.
// Reset clears all control state; the entry RAM holds no reset value and needs none.
// The receiver takes every result strobe; the front end stalls only when the queue is full.
module zone_grid_key_sort (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  zgks_pkg::item_t             item,
	output logic                        result_valid,
	output zgks_pkg::result_t           result,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [zgks_pkg::BANK_W-1:0] cfg_data
);
	import zgks_pkg::*;

	logic [BANK_W-1:0] bank_width_q, bank_height_q;
	logic push, q_full, pop, not_empty;
	qword_t push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_width_q <= BANK_W'(256);
			bank_height_q <= BANK_W'(256);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BANK_WIDTH: bank_width_q <= cfg_data;
				CFG_BANK_HEIGHT: bank_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	zgks_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.bank_width  (bank_width_q),
		.bank_height (bank_height_q),
		.push        (push),
		.push_data   (push_data),
		.q_full      (q_full)
	);

	zgks_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_data  (pop_data)
	);

	zgks_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.not_empty    (not_empty),
		.pop_data     (pop_data),
		.pop          (pop),
		.result_valid (result_valid),
		.result       (result)
	);
endmodule
